>>> hw/rtl/rlab_pkg.sv
`timescale 1ns / 1ps
// shared constants, matrices and table builders for the l-alpha-beta converter
package rlab_pkg;

    localparam int PIX_W    = 24;
    localparam int MAT_LAT  = 2;
    localparam int CHAN_LAT = 6;

    localparam logic signed [PIX_W-1:0] PIX_MAX = 24'sh7FFFFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 24'sh800000;

    // log10(2) in Q28 and log2(10) in Q28
    localparam logic signed [27:0] K_LOG10_2 = 28'sd80807124;
    localparam logic        [26:0] K_LOG10_2_U = 27'd80807124;
    localparam logic signed [30:0] K_LOG2_10 = 31'sd891723284;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // four-decimal matrices scaled by 10000, row major
    localparam int M_RGB_LMS [9] = '{3811, 5783, 402, 1967, 7244, 782, 241, 1288, 8444};
    localparam int M_LMS_RGB [9] = '{44679, -35873, 1193, -12186, 23809, -1624,
                                     497, -2439, 12045};
    localparam int M_LMS_LAB [9] = '{5773, 5773, 5773, 4082, 4082, -8164, 7071, -7071, 0};
    localparam int M_LAB_LMS [9] = '{5773, 4082, 7071, 5773, 4082, -7071, 5773, -8164, 0};

    // coefficient in Qf, rounded half away from zero
    function automatic int coef(int m, int f);
        longint c;
        c = longint'(m) <<< f;
        if (m >= 0) c = c + 5000;
        else c = c - 5000;
        return int'(c / 10000);
    endfunction

    // truncating integer square root
    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned x;
        r = 0;
        b = 64'd1 << 62;
        x = v;
        for (int k = 0; k < 32; k++) begin
            if (b > x) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2(1 + i / 2^tb) in Q30 by repeated squaring
    function automatic longint unsigned log_entry(int i, int tb);
        longint unsigned x;
        longint unsigned res;
        if (i >= (1 << tb)) return ONE_Q30;
        x = ONE_Q30 + (longint'(i) << (30 - tb));
        res = 0;
        for (int k = 1; k <= 30; k++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                res = res | (64'd1 << (30 - k));
            end
        end
        return res;
    endfunction

    // 2^(i / 2^tb) in Q30 from products of repeated roots of two
    function automatic longint unsigned pow_entry(int i, int tb);
        longint unsigned root [17];
        longint unsigned p;
        if (i >= (1 << tb)) return 64'd2 << 30;
        for (int k = 0; k < 17; k++) root[k] = 0;
        root[0] = 64'd2 << 30;
        for (int k = 1; k <= tb; k++) root[k] = isqrt64(root[k-1] << 30);
        p = ONE_Q30;
        for (int k = 0; k < tb; k++) begin
            if (((i >> k) & 1) != 0) p = (p * root[tb-k]) >> 30;
        end
        return p;
    endfunction

endpackage

>>> hw/rtl/rlab_mat.sv
`timescale 1ns / 1ps
// pipelined 3x3 fixed-point matrix stage with rounding and saturation
module rlab_mat import rlab_pkg::*; #(
    parameter int F = 12,
    localparam int CW = F + 4
) (
    input  logic                    i_clk,
    input  logic signed [PIX_W-1:0] i_x    [3],
    input  logic signed [CW-1:0]    i_coef [9],
    output logic signed [PIX_W-1:0] o_y    [3]
);

    localparam int PW = CW + PIX_W;
    localparam int SW = PW + 2;

    logic signed [PW-1:0]    r_prod [9];
    logic signed [PIX_W-1:0] r_y    [3];

    // products, one multiplier per coefficient
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 9; g++) begin
            r_prod[g] <= PW'(i_coef[g]) * PW'(i_x[g % 3]);
        end
    end

    // row sums, round half up, saturate
    for (genvar row = 0; row < 3; row++) begin : g_row
        logic signed [SW-1:0] w_sum;
        logic signed [SW-1:0] w_rs;
        assign w_sum = SW'(r_prod[3*row]) + SW'(r_prod[3*row+1]) + SW'(r_prod[3*row+2]);
        assign w_rs  = (w_sum + (SW'(1) <<< (F - 1))) >>> F;
        always_ff @(posedge i_clk) begin
            if (w_rs > SW'(PIX_MAX)) r_y[row] <= PIX_MAX;
            else if (w_rs < SW'(PIX_MIN)) r_y[row] <= PIX_MIN;
            else r_y[row] <= w_rs[PIX_W-1:0];
        end
    end

    assign o_y = r_y;

endmodule

>>> hw/rtl/rlab_chan.sv
`timescale 1ns / 1ps
// per-channel log10(x+1) and 10^x-1 pipelines with interpolated tables
module rlab_chan import rlab_pkg::*; #(
    parameter int F = 12,
    parameter int T = 8
) (
    input  logic                    i_clk,
    input  logic signed [PIX_W-1:0] i_x,
    output logic signed [PIX_W-1:0] o_log,
    output logic signed [PIX_W-1:0] o_exp
);

    localparam int TAB = (1 << T) + 1;
    localparam int RW  = 30 - T;
    localparam int PRW = 31 + RW;

    // constant tables
    logic [31:0] w_log_tab [TAB];
    logic [31:0] w_pow_tab [TAB];
    for (genvar g = 0; g < TAB; g++) begin : g_tab
        assign w_log_tab[g] = 32'(log_entry(g, T));
        assign w_pow_tab[g] = 32'(pow_entry(g, T));
    end

    // stage 1: leading one and mantissa for log, scaling product for exp
    logic signed [PIX_W:0] w_y;
    logic [4:0]            w_p;
    logic [54:0]           w_sh;
    logic                  r1_neg;
    logic [4:0]            r1_p;
    logic [29:0]           r1_frac;
    logic signed [54:0]    r1_pe;

    assign w_y = (PIX_W+1)'(i_x) + ((PIX_W+1)'(1) <<< F);
    always_comb begin
        w_p = '0;
        for (int q = 0; q < PIX_W; q++) begin
            if (w_y[q]) w_p = 5'(q);
        end
    end
    assign w_sh = 55'(w_y[PIX_W-1:0]) << (6'd30 - 6'(w_p));

    always_ff @(posedge i_clk) begin
        r1_neg  <= w_y[PIX_W] | (w_y == '0);
        r1_p    <= w_p;
        r1_frac <= w_sh[29:0];
        r1_pe   <= i_x * K_LOG2_10;
    end

    // stage 2: table reads, exponent split
    logic [T-1:0]       w_lidx;
    logic [T-1:0]       w_eidx;
    logic signed [54:0] w_e;
    logic signed [24:0] w_n;
    logic [29:0]        w_ef;
    logic [31:0]        r2_lta, r2_eta;
    logic [30:0]        r2_ldiff, r2_ediff;
    logic [RW-1:0]      r2_lr, r2_er;
    logic [4:0]         r2_p;
    logic               r2_neg, r2_sat, r2_zero;
    logic [5:0]         r2_m;

    assign w_lidx = r1_frac[29 -: T];
    assign w_e    = r1_pe >>> (F - 2);
    assign w_n    = w_e[54:30];
    assign w_ef   = w_e[29:0];
    assign w_eidx = w_ef[29 -: T];

    always_ff @(posedge i_clk) begin
        r2_lta   <= w_log_tab[{1'b0, w_lidx}];
        r2_ldiff <= 31'(w_log_tab[(T+1)'({1'b0, w_lidx}) + (T+1)'(1)]
                       - w_log_tab[{1'b0, w_lidx}]);
        r2_lr    <= r1_frac[RW-1:0];
        r2_p     <= r1_p;
        r2_neg   <= r1_neg;
        r2_eta   <= w_pow_tab[{1'b0, w_eidx}];
        r2_ediff <= 31'(w_pow_tab[(T+1)'({1'b0, w_eidx}) + (T+1)'(1)]
                       - w_pow_tab[{1'b0, w_eidx}]);
        r2_er    <= w_ef[RW-1:0];
        r2_sat   <= w_n >= 25'(30 - F);
        r2_zero  <= w_n <= 25'(-3 - F);
        r2_m     <= 6'(6'(30 - F) - w_n[5:0]);
    end

    // stage 3: interpolation products
    logic [PRW-1:0] r3_lprod, r3_eprod;
    logic [31:0]    r3_lta, r3_eta;
    logic [4:0]     r3_p;
    logic           r3_neg, r3_sat, r3_zero;
    logic [5:0]     r3_m;

    always_ff @(posedge i_clk) begin
        r3_lprod <= PRW'(r2_ldiff) * PRW'(r2_lr);
        r3_eprod <= PRW'(r2_ediff) * PRW'(r2_er);
        r3_lta   <= r2_lta;
        r3_eta   <= r2_eta;
        r3_p     <= r2_p;
        r3_neg   <= r2_neg;
        r3_sat   <= r2_sat;
        r3_zero  <= r2_zero;
        r3_m     <= r2_m;
    end

    // stage 4: interpolated values, exp shift and saturation
    logic [31:0]        w_ev;
    logic [33:0]        w_rv;
    logic signed [34:0] w_vm;
    logic [31:0]        r4_lt;
    logic [4:0]         r4_p;
    logic               r4_neg;
    logic signed [PIX_W-1:0] r4_exp;

    assign w_ev = r3_eta + 32'(r3_eprod >> RW);
    assign w_rv = (34'(w_ev) + (34'd1 << (r3_m - 6'd1))) >> r3_m;
    assign w_vm = $signed({1'b0, w_rv}) - (35'sd1 <<< F);

    always_ff @(posedge i_clk) begin
        r4_lt  <= r3_lta + 32'(r3_lprod >> RW);
        r4_p   <= r3_p;
        r4_neg <= r3_neg;
        if (r3_sat) r4_exp <= PIX_MAX;
        else if (r3_zero) r4_exp <= -(PIX_W'(1) <<< F);
        else if (w_vm > 35'(PIX_MAX)) r4_exp <= PIX_MAX;
        else r4_exp <= w_vm[PIX_W-1:0];
    end

    // stage 5: scale log2 to log10
    logic signed [6:0]  w_pf;
    logic signed [34:0] r5_lhi;
    logic [58:0]        r5_llo;
    logic               r5_neg;
    logic signed [PIX_W-1:0] r5_exp;

    assign w_pf = $signed(7'(r4_p)) - 7'(F);

    always_ff @(posedge i_clk) begin
        r5_lhi <= 35'(w_pf) * 35'(K_LOG10_2);
        r5_llo <= 59'(r4_lt) * 59'(K_LOG10_2_U);
        r5_neg <= r4_neg;
        r5_exp <= r4_exp;
    end

    // stage 6: combine, round to Qf, saturate
    logic signed [63:0] w_sum;
    logic signed [63:0] w_rs;
    logic signed [PIX_W-1:0] r6_log, r6_exp;

    assign w_sum = (64'(r5_lhi) <<< 30) + $signed({5'b0, r5_llo});
    assign w_rs  = (w_sum + (64'sd1 <<< (57 - F))) >>> (58 - F);

    always_ff @(posedge i_clk) begin
        if (r5_neg) r6_log <= PIX_MIN;
        else if (w_rs > 64'(PIX_MAX)) r6_log <= PIX_MAX;
        else if (w_rs < 64'(PIX_MIN)) r6_log <= PIX_MIN;
        else r6_log <= w_rs[PIX_W-1:0];
        r6_exp <= r5_exp;
    end

    assign o_log = r6_log;
    assign o_exp = r6_exp;

endmodule

>>> hw/rtl/rgb_lab_color_convert_core.sv
`timescale 1ns / 1ps
// top level of the rgb / l-alpha-beta pixel converter
// One pixel item is taken every clock (busy stays low). Each result is driven with o_done high
// for that one cycle; the receiver cannot stall.
// The pipeline is the first matrix (2 stages), the per-channel log or exponent
// pipeline (6 stages) and the second matrix (2 stages). The direction register
// is sampled when an item is accepted; write it only while no item is in flight.
module rgb_lab_color_convert_core import rlab_pkg::*; #(
    parameter int FRACTION_BITS  = 12,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_wdata,
    input  logic signed [PIX_W-1:0] i_in_first,
    input  logic signed [PIX_W-1:0] i_in_second,
    input  logic signed [PIX_W-1:0] i_in_third,
    output logic                    o_done,
    output logic signed [PIX_W-1:0] o_out_first,
    output logic signed [PIX_W-1:0] o_out_second,
    output logic signed [PIX_W-1:0] o_out_third
);

    localparam int CW  = FRACTION_BITS + 4;
    localparam int LAT = 2 * MAT_LAT + CHAN_LAT;
    localparam int MID = MAT_LAT + CHAN_LAT - 1;

    logic           r_direction;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_dir;

    // direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_direction <= 1'b0;
        else if (i_cfg_we) r_direction <= i_cfg_wdata;
    end

    // valid and direction travel with each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_dir <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
            r_dir <= {r_dir[LAT-2:0], r_direction};
        end
    end

    assign busy = 1'b0;

    // coefficient sets
    logic signed [CW-1:0] w_c_rgb_lms [9], w_c_lab_lms [9], w_c_lms_lab [9], w_c_lms_rgb [9];
    logic signed [CW-1:0] w_c1 [9], w_c2 [9];
    for (genvar g = 0; g < 9; g++) begin : g_coef
        assign w_c_rgb_lms[g] = CW'(coef(M_RGB_LMS[g], FRACTION_BITS));
        assign w_c_lab_lms[g] = CW'(coef(M_LAB_LMS[g], FRACTION_BITS));
        assign w_c_lms_lab[g] = CW'(coef(M_LMS_LAB[g], FRACTION_BITS));
        assign w_c_lms_rgb[g] = CW'(coef(M_LMS_RGB[g], FRACTION_BITS));
        assign w_c1[g] = r_direction ? w_c_lab_lms[g] : w_c_rgb_lms[g];
        assign w_c2[g] = r_dir[MID] ? w_c_lms_rgb[g] : w_c_lms_lab[g];
    end

    // first matrix
    logic signed [PIX_W-1:0] w_a [3], w_b [3], w_b2 [3], w_o [3];
    assign w_a[0] = i_in_first;
    assign w_a[1] = i_in_second;
    assign w_a[2] = i_in_third;

    rlab_mat #(.F(FRACTION_BITS)) u_mat_in (
        .i_clk  (i_clk),
        .i_x    (w_a),
        .i_coef (w_c1),
        .o_y    (w_b)
    );

    // per-channel nonlinearity, chosen by the item's direction
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic signed [PIX_W-1:0] w_log, w_exp;
        rlab_chan #(.F(FRACTION_BITS), .T(LOG_TABLE_BITS)) u_chan (
            .i_clk (i_clk),
            .i_x   (w_b[c]),
            .o_log (w_log),
            .o_exp (w_exp)
        );
        assign w_b2[c] = r_dir[MID] ? w_exp : w_log;
    end

    // second matrix
    rlab_mat #(.F(FRACTION_BITS)) u_mat_out (
        .i_clk  (i_clk),
        .i_x    (w_b2),
        .i_coef (w_c2),
        .o_y    (w_o)
    );

    assign o_done       = r_vld[LAT-1];
    assign o_out_first  = w_o[0];
    assign o_out_second = w_o[1];
    assign o_out_third  = w_o[2];

`ifndef ASSERT_OFF
    // every result traces back to an accepted item
    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without accepted item");

    // a zero pixel maps to zero in both directions
    a_zero_maps_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_in_first == '0 && i_in_second == '0 && i_in_third == '0, LAT))
        |-> (o_out_first == '0 && o_out_second == '0 && o_out_third == '0))
        else $error("zero pixel did not convert to zero");
`endif

endmodule
